// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// ===== rtl/edtk_pkg.sv =====
package edtk_pkg;
    localparam int MaxDim = 1024;
    localparam int MaxK = 64;
    localparam int DimW = $clog2(MaxDim);
    localparam int KW = $clog2(MaxK);
    localparam int DistW = 44;
    localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

    localparam logic [0:0] CfgTopK = 1'b0;
    localparam logic [0:0] CfgVecLen = 1'b1;

    // One finished candidate handed from the accumulator to the list keeper.
    typedef struct packed {
        logic [DistW-1:0] distance;
        logic [31:0]      id;
        logic             run_end;
    } cand_t;
endpackage

// ===== rtl/edtk_front.sv =====
module edtk_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic signed [15:0]   element_value,
    input  logic [15:0]          cluster_index,
    input  logic [15:0]          offset_index,
    input  logic                 last_element,
    input  logic                 last_candidate,
    input  logic [10:0]          vector_length,
    output logic                 cand_valid,
    input  logic                 cand_ready,
    output edtk_pkg::cand_t      cand
);
    import edtk_pkg::*;

    // Two-stage pipeline: stage one reads the query memory, stage two squares and adds.
    logic [15:0]       query_mem [MaxDim];
    logic [15:0]       q_rd_reg;
    logic [11:0]       pos_reg, pos_next;
    logic              s1_valid_reg;
    logic              s1_mode_reg, s1_use_reg, s1_last_reg, s1_run_reg;
    logic signed [15:0] s1_val_reg;
    logic [31:0]       s1_id_reg;
    logic [DistW-1:0]  sum_reg;
    logic              cv_reg;
    cand_t             cand_reg;
    logic [11:0]       limit;
    logic              use_now, acc, s1_fire;
    logic signed [16:0] diff;
    logic [33:0]       sq;
    logic [DistW:0]    total;
    logic [DistW-1:0]  sum_sat;

    assign limit = (vector_length > 11'(MaxDim)) ? 12'(MaxDim) : {1'b0, vector_length};
    assign use_now = pos_reg < limit;
    // Stall stage one while its end-of-vector output cannot be placed.
    assign s1_fire = s1_valid_reg && !(s1_last_reg && s1_mode_reg && cv_reg && !cand_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign acc = in_valid && in_ready;
    assign pos_next = (acc && last_element) ? '0 : ((acc && use_now) ? pos_reg + 1'b1 : pos_reg);

    always_ff @(posedge clk)
    begin
        if (acc && use_now && !mode)
        begin
            query_mem[pos_reg[DimW-1:0]] <= element_value;
        end
        if (acc)
        begin
            q_rd_reg <= query_mem[pos_reg[DimW-1:0]];
            s1_val_reg <= element_value;
            s1_id_reg <= {cluster_index, offset_index};
            s1_mode_reg <= mode;
            s1_use_reg <= use_now;
            s1_last_reg <= last_element;
            s1_run_reg <= last_candidate;
        end
    end

    assign diff = 17'(s1_val_reg) - 17'($signed(q_rd_reg));
    assign sq = 34'(diff * diff);
    assign total = {1'b0, sum_reg} + ((s1_use_reg && s1_mode_reg) ? (DistW+1)'(sq) : '0);
    assign sum_sat = total[DistW] ? DistMax : total[DistW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            s1_valid_reg <= 1'b0;
            sum_reg <= '0;
            cv_reg <= 1'b0;
            cand_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (acc)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            if (s1_fire)
                sum_reg <= s1_last_reg ? '0 : sum_sat;
            // A new candidate may replace the one taken in the same cycle.
            if (s1_fire && s1_last_reg && s1_mode_reg)
            begin
                cv_reg <= 1'b1;
                cand_reg <= '{distance: sum_sat, id: s1_id_reg, run_end: s1_run_reg};
            end
            else if (cand_ready)
                cv_reg <= 1'b0;
        end
    end

    assign cand_valid = cv_reg;
    assign cand = cand_reg;
endmodule

// ===== rtl/edtk_back.sv =====
module edtk_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cand_valid,
    output logic                 cand_ready,
    input  edtk_pkg::cand_t      cand,
    input  logic [6:0]           top_k,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          out_cluster,
    output logic [15:0]          out_offset,
    output logic [43:0]          out_distance,
    output logic                 last_result
);
    import edtk_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_WALK = 4'b0010, S_EREAD = 4'b0100, S_EOUT = 4'b1000
    } st_t;

    typedef struct packed {
        logic [DistW-1:0] distance;
        logic [31:0]      id;
    } entry_t;

    // Sorted list in a memory with one registered read and one write per cycle.
    // Insertion walks up from the bottom of the list, moving each larger entry
    // down by one slot until the new candidate's slot is found.
    entry_t           list_mem [MaxK];
    entry_t           rd_reg;
    st_t              st_reg;
    logic [KW:0]      kept_reg, idx_reg;
    cand_t            c_reg;
    logic [KW:0]      cap;
    logic [KW:0]      kept_c;
    logic [KW-1:0]    rd_addr;
    logic             wr_en;
    logic [KW-1:0]    wr_addr;
    entry_t           wr_data;
    logic             move, load_out;
    logic             ov_reg;
    logic [15:0]      oc_reg, oo_reg;
    logic [DistW-1:0] od_reg;
    logic             ol_reg;

    assign cap = (top_k > 7'(MaxK)) ? (KW+1)'(MaxK) : (KW+1)'(top_k);
    assign kept_c = (kept_reg > cap) ? cap : kept_reg;
    assign cand_ready = (st_reg == S_IDLE);

    // The entry just above the open slot is larger: it moves down.
    assign move = (idx_reg != '0) && (rd_reg.distance > c_reg.distance);
    assign load_out = (st_reg == S_EOUT) && (!ov_reg || out_ready);

    always_comb
    begin
        case (st_reg)
            S_IDLE:  rd_addr = KW'(kept_c - 1'b1);
            S_WALK:  rd_addr = KW'(idx_reg - 2'd2);
            default: rd_addr = idx_reg[KW-1:0];
        endcase
    end

    // Slots at or beyond the capacity are never written; the worst entry drops out.
    assign wr_en = (st_reg == S_WALK) && (idx_reg < cap);
    assign wr_addr = idx_reg[KW-1:0];
    assign wr_data = move ? rd_reg : '{distance: c_reg.distance, id: c_reg.id};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            list_mem[wr_addr] <= wr_data;
        rd_reg <= list_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            kept_reg <= '0;
            idx_reg <= '0;
            c_reg <= '0;
            ov_reg <= 1'b0;
            oc_reg <= '0;
            oo_reg <= '0;
            od_reg <= '0;
            ol_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                ov_reg <= 1'b1;
                oc_reg <= rd_reg.id[31:16];
                oo_reg <= rd_reg.id[15:0];
                od_reg <= rd_reg.distance;
                ol_reg <= (idx_reg + 1'b1 == kept_c);
            end
            else if (out_ready)
                ov_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (cand_valid)
                    begin
                        c_reg <= cand;
                        idx_reg <= kept_c;
                        kept_reg <= (kept_c < cap) ? kept_c + 1'b1 : kept_c;
                        st_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (move)
                        idx_reg <= idx_reg - 1'b1;
                    else
                    begin
                        idx_reg <= '0;
                        st_reg <= c_reg.run_end ? S_EREAD : S_IDLE;
                    end
                end
                S_EREAD:
                begin
                    if (idx_reg >= kept_c)
                    begin
                        kept_reg <= '0;
                        st_reg <= S_IDLE;
                    end
                    else
                        st_reg <= S_EOUT;
                end
                S_EOUT:
                begin
                    if (load_out)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        st_reg <= S_EREAD;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign out_cluster = oc_reg;
    assign out_offset = oo_reg;
    assign out_distance = od_reg;
    assign last_result = ol_reg;

`include "assert_macros.svh"
    `ASSERT_CLK(a_kept_cap, kept_reg <= (KW+1)'(MaxK), "kept count beyond list size")
    `ASSERT_CLK(a_take_walk, (cand_valid && cand_ready) |=> st_reg == S_WALK, "take not walked")
    `ASSERT_CLK(a_out_emit, (out_valid && !$past(out_valid)) |-> $past(st_reg) == S_EOUT,
        "result outside emission")
    `ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_distance)),
        "stalled result not held")
endmodule

// ===== rtl/exact_distance_top_k.sv =====
// Exact squared-distance re-ranking with top-k selection.
// Input stream (s_axis): one vector element per transfer. tuser carries the mode:
// 0 loads the query, 1 streams a candidate. tlast marks the last element of a
// vector; tdata packs value, cluster, offset and last_candidate.
// Output stream (m_axis): one neighbor per transfer in ascending distance, with
// tlast on the final neighbor of the run. A run with nothing kept sends nothing.
// Configuration: cfg_we writes top_k (index 0) or vector_length (index 1). The
// user writes only while no transfer is in flight; the block does not enforce it.
// Elements are accepted one per cycle while s_axis_tready is high. The
// accumulator reads the query memory, then squares and adds with 44-bit
// saturation, and hands each finished candidate to the list keeper, which walks
// its sorted list from the bottom with one memory read and one write per cycle.
// One candidate waits in the hand-off register while the keeper is busy, so the
// input stalls when a candidate vector ends while that register is still full.
// At the end of a run the keeper reads its entries in ascending order, through
// S_EREAD and S_EOUT, into the output register. A stalled receiver holds the
// output register, then the keeper, then the input. Reset empties the list,
// clears position and sum, and sets top_k to 10 and vector_length to 128; the
// query memory is not cleared.
module exact_distance_top_k (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [0:0]    cfg_index,
    input  logic [10:0]   cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [55:0]   s_axis_tdata,  // value, cluster, offset, last_candidate, pad
    input  logic          s_axis_tuser,  // mode
    input  logic          s_axis_tlast,  // last_element
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [79:0]   m_axis_tdata,  // out_cluster, out_offset, out_distance, pad
    output logic          m_axis_tlast   // last_result
);
    import edtk_pkg::*;

    logic [6:0]  top_k_reg;
    logic [10:0] vlen_reg;
    logic        cand_valid, cand_ready;
    cand_t       cand;
    logic [15:0] oc, oo;
    logic [43:0] od;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_k_reg <= 7'd10;
            vlen_reg <= 11'd128;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CfgTopK:   top_k_reg <= cfg_data[6:0];
                CfgVecLen: vlen_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    edtk_front u_front (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .mode(s_axis_tuser), .element_value(s_axis_tdata[15:0]),
        .cluster_index(s_axis_tdata[31:16]), .offset_index(s_axis_tdata[47:32]),
        .last_element(s_axis_tlast), .last_candidate(s_axis_tdata[48]),
        .vector_length(vlen_reg),
        .cand_valid, .cand_ready, .cand
    );

    edtk_back u_back (
        .clk, .rst_n, .cand_valid, .cand_ready, .cand, .top_k(top_k_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_cluster(oc), .out_offset(oo), .out_distance(od), .last_result(m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, od, oo, oc};
endmodule
